>>> src/slx_pkg.sv
package slx_pkg;

  // Scanner modes
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_INTEGER = 2'd2,
    MODE_IDENT   = 2'd3
  } mode_e;

  // Token kinds beyond the punctuation range
  localparam logic [4:0] KIND_STRING  = 5'd13;
  localparam logic [4:0] KIND_INTEGER = 5'd14;
  localparam logic [4:0] KIND_BOOL    = 5'd15;
  localparam logic [4:0] KIND_IF      = 5'd16;
  localparam logic [4:0] KIND_WHILE   = 5'd17;
  localparam logic [4:0] KIND_IDENT   = 5'd18;

  localparam int unsigned NUM_PUNCT = 13;
  localparam int unsigned PREFIX_LEN = 5;

  // Punctuation bytes, kind = index
  localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
    8'h3B, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D,
    8'h3C, 8'h3E, 8'h2C
  };

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // Queue between scanner and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // Token without its length (length width is a top-level parameter)
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] line;
  } tok_t;

  localparam int unsigned TOK_W = $bits(tok_t);

endpackage

>>> src/slx_scan.sv
module slx_scan
  import slx_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config
  input  logic                   cfg_valid_i,
  input  logic [31:0]            cfg_data_i,
  // byte stream
  input  logic                   in_valid_i,
  input  logic                   q_full_i,
  input  logic [7:0]             char_byte_i,
  input  logic                   end_of_input_i,
  // queue push
  output logic                   push_o,
  output logic                   two_o,
  output tok_t                   tok_a_o,
  output logic [LENGTH_BITS-1:0] len_a_o,
  output tok_t                   tok_b_o,
  output logic [LENGTH_BITS-1:0] len_b_o
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  mode_e                  mode_q, mode_d;
  logic [31:0]            start_line_q;
  logic [31:0]            line_q, line_d;
  logic [31:0]            pline_q, pline_d;
  logic [LENGTH_BITS-1:0] plen_q, plen_d;
  logic [7:0]             prefix_q [PREFIX_LEN];
  logic [7:0]             prefix_d [PREFIX_LEN];
  logic                   bs_q, bs_d;

  logic                   accept;
  logic [LENGTH_BITS-1:0] grown;
  logic                   is_nl, is_sp, is_dig, is_alnum;
  logic                   punct_hit;
  logic [4:0]             punct_idx;
  logic [4:0]             id_kind;
  logic                   flushed, do_idle, idle_emit;
  logic [4:0]             flush_kind;
  logic [LENGTH_BITS-1:0] flush_len;
  tok_t                   flush_tok, idle_tok;

  assign accept = in_valid_i && !q_full_i;
  assign grown  = (plen_q == LEN_MAX) ? plen_q : plen_q + 1'b1;

  assign is_nl    = (char_byte_i == CH_LF) || (char_byte_i == CH_CR);
  assign is_sp    = (char_byte_i == CH_SPACE) || (char_byte_i == CH_TAB);
  assign is_dig   = (char_byte_i >= 8'h30) && (char_byte_i <= 8'h39);
  assign is_alnum = is_dig || ((char_byte_i >= 8'h41) && (char_byte_i <= 8'h5A))
                  || ((char_byte_i >= 8'h61) && (char_byte_i <= 8'h7A));

  always_comb begin
    punct_hit = 1'b0;
    punct_idx = '0;
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (!punct_hit && char_byte_i == PUNCT_CHARS[i]) begin
        punct_hit = 1'b1;
        punct_idx = 5'(i);
      end
    end
  end

  // keyword / boolean match on the kept prefix
  always_comb begin
    id_kind = KIND_IDENT;
    if ((plen_q == LENGTH_BITS'(5) &&
         {prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3], prefix_q[4]} == "false") ||
        (plen_q == LENGTH_BITS'(4) &&
         {prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3]} == "true")) begin
      id_kind = KIND_BOOL;
    end else if (plen_q == LENGTH_BITS'(2) && {prefix_q[0], prefix_q[1]} == "if") begin
      id_kind = KIND_IF;
    end else if (plen_q == LENGTH_BITS'(5) &&
                 {prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3], prefix_q[4]}
                 == "while") begin
      id_kind = KIND_WHILE;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_STRING:  flush_kind = KIND_STRING;
      MODE_INTEGER: flush_kind = KIND_INTEGER;
      default:      flush_kind = id_kind;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    pline_d   = pline_q;
    plen_d    = plen_q;
    prefix_d  = prefix_q;
    bs_d      = bs_q;
    flushed   = 1'b0;
    do_idle   = 1'b0;
    idle_emit = 1'b0;
    flush_len = plen_q;
    idle_tok  = '{kind: punct_idx, line: line_q};

    if (end_of_input_i) begin
      flushed = (mode_q != MODE_IDLE);
      mode_d  = MODE_IDLE;
      line_d  = start_line_q;
      bs_d    = 1'b0;
    end else begin
      case (mode_q)
        MODE_STRING: begin
          plen_d = grown;
          if (is_nl) begin
            line_d = line_q + 32'd1;
          end
          if (bs_q) begin
            bs_d = 1'b0;
          end else if (char_byte_i == CH_BSL) begin
            bs_d = 1'b1;
          end else if (char_byte_i == CH_QUOTE) begin
            flushed   = 1'b1;
            flush_len = grown;
            mode_d    = MODE_IDLE;
          end
        end
        MODE_INTEGER, MODE_IDENT: begin
          if ((mode_q == MODE_INTEGER) ? is_dig : is_alnum) begin
            if (plen_q < LENGTH_BITS'(PREFIX_LEN)) begin
              prefix_d[plen_q[2:0]] = char_byte_i;
            end
            plen_d = grown;
          end else begin
            flushed = 1'b1;
            do_idle = 1'b1;
            mode_d  = MODE_IDLE;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    // byte scanned from idle; may follow a flush in the same step
    if (do_idle) begin
      if (is_sp) begin
        // separator only
      end else if (is_nl) begin
        line_d = line_q + 32'd1;
      end else if (punct_hit) begin
        idle_emit = 1'b1;
      end else begin
        if (char_byte_i == CH_QUOTE) begin
          mode_d = MODE_STRING;
        end else if (is_dig) begin
          mode_d = MODE_INTEGER;
        end else begin
          mode_d = MODE_IDENT;
        end
        pline_d = line_q;
        plen_d  = LENGTH_BITS'(1);
        bs_d    = 1'b0;
        for (int i = 0; i < PREFIX_LEN; i++) begin
          prefix_d[i] = '0;
        end
        prefix_d[0] = char_byte_i;
      end
    end
  end

  assign flush_tok = '{kind: flush_kind, line: pline_q};

  assign push_o  = accept && (flushed || idle_emit);
  assign two_o   = flushed && idle_emit;
  assign tok_a_o = flushed ? flush_tok : idle_tok;
  assign len_a_o = flushed ? flush_len : LENGTH_BITS'(1);
  assign tok_b_o = idle_tok;
  assign len_b_o = LENGTH_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      start_line_q <= 32'd1;
      line_q       <= 32'd1;
      pline_q      <= '0;
      plen_q       <= '0;
      bs_q         <= 1'b0;
      for (int i = 0; i < PREFIX_LEN; i++) begin
        prefix_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        mode_q   <= mode_d;
        line_q   <= line_d;
        pline_q  <= pline_d;
        plen_q   <= plen_d;
        bs_q     <= bs_d;
        prefix_q <= prefix_d;
      end
      if (cfg_valid_i) begin
        start_line_q <= cfg_data_i;
        line_q       <= cfg_data_i;
      end
    end
  end

  // end of text leaves the scanner idle with the line count reloaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_input_i |=> mode_q == MODE_IDLE && line_q == start_line_q)
    else $error("scanner not idle after end of input");

  // a second token only follows a flushed identifier or integer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && two_o |-> (mode_q == MODE_INTEGER || mode_q == MODE_IDENT)
                        && !end_of_input_i)
    else $error("two tokens from a byte that cannot end a token");

endmodule

>>> src/slx_queue.sv
module slx_queue
  import slx_pkg::*;
#(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

endmodule

>>> src/slx_emit.sv
module slx_emit
  import slx_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  logic [2*(TOK_W+LENGTH_BITS):0] q_data_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [4:0]             token_kind_o,
  output logic [31:0]            token_line_o,
  output logic [LENGTH_BITS-1:0] token_length_o,
  output logic                   last_result_o
);

  logic                   two;
  tok_t                   tok_a, tok_b, tok_pick;
  logic [LENGTH_BITS-1:0] len_a, len_b, len_pick;
  logic                   last_pick;

  logic                   valid_q, valid_d;
  logic                   sel_b_q, sel_b_d;
  logic                   load;

  logic [4:0]             kind_q;
  logic [31:0]            line_q;
  logic [LENGTH_BITS-1:0] len_q;
  logic                   last_q;

  assign {two, tok_a, len_a, tok_b, len_b} = q_data_i;

  assign tok_pick  = sel_b_q ? tok_b : tok_a;
  assign len_pick  = sel_b_q ? len_b : len_a;
  assign last_pick = sel_b_q || !two;

  always_comb begin
    load    = !valid_q || !out_stall_i;
    valid_d = valid_q;
    sel_b_d = sel_b_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        q_pop_o = last_pick;
        sel_b_d = !last_pick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_b_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_b_q <= sel_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      kind_q <= tok_pick.kind;
      line_q <= tok_pick.line;
      len_q  <= len_pick;
      last_q <= last_pick;
    end
  end

  assign out_valid_o    = valid_q;
  assign token_kind_o   = kind_q;
  assign token_line_o   = line_q;
  assign token_length_o = len_q;
  assign last_result_o  = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  // the second token of a pair is always the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && q_valid_i && sel_b_q |=> last_result_o)
    else $error("second token not marked last");

endmodule

>>> src/source_text_lexer_core.sv
// Source text lexer: scans one source byte per transfer and returns tokens.
//
// Input channel (in_valid_i / in_stall_o): char_byte_i and end_of_input_i.
//   A byte is taken in every cycle unless the token queue is full.
// Output channel (out_valid_o / out_stall_i): token_kind_o, token_line_o,
//   token_length_o, last_result_o; one token per transfer.
// Config channel (cfg_valid_i / cfg_ready_o): writes start_line, which also
//   reloads the running line count. Ready is always high; write only while
//   the block is idle.
// Tokens go through the queue, then the output register. Throughput: one
//   byte per cycle in unless the queue is full, one token per cycle out
//   unless stalled; a byte ending an identifier or integer that is itself
//   punctuation yields two tokens: output sets the pace when those cluster.
// A 4-entry queue of per-byte token pairs decouples the scanner from the
//   output register, so output stalls reach in_stall_o only when it fills.
// Reset: scanner idle, start_line and line count 1, queue and output empty.
module source_text_lexer_core
  import slx_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [31:0]            cfg_data_i,
  // byte input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_byte_i,
  input  logic                   end_of_input_i,
  // token output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [4:0]             token_kind_o,
  output logic [31:0]            token_line_o,
  output logic [LENGTH_BITS-1:0] token_length_o,
  output logic                   last_result_o
);

  // queue entry: pair flag, first token, second token
  localparam int unsigned ENTRY_W = 2 * (TOK_W + LENGTH_BITS) + 1;

  logic                   push;
  logic                   two;
  tok_t                   tok_a, tok_b;
  logic [LENGTH_BITS-1:0] len_a, len_b;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [ENTRY_W-1:0]     q_data;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  // front: classify bytes, track lines and pending token
  slx_scan #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .in_valid_i,
    .q_full_i (q_full),
    .char_byte_i,
    .end_of_input_i,
    .push_o   (push),
    .two_o    (two),
    .tok_a_o  (tok_a),
    .len_a_o  (len_a),
    .tok_b_o  (tok_b),
    .len_b_o  (len_b)
  );

  slx_queue #(
    .DATA_W(ENTRY_W)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  ({two, tok_a, len_a, tok_b, len_b}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back: serialize token pairs onto the output register
  slx_emit #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_emit (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .token_kind_o,
    .token_line_o,
    .token_length_o,
    .last_result_o
  );

endmodule
